### hdl/assert_macros.svh
// Assertion helpers used by the checker file sfep_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk and held off during rst.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/sfep_pkg.sv
package sfep_pkg;

  localparam int ADDR_W  = 21;
  localparam int REM_W   = 22;
  localparam int START_W = 20;
  localparam int COUNT_W = 21;
  localparam int MAX_OPS = 48;
  localparam int OPS_W   = $clog2(MAX_OPS);

  localparam logic [REM_W-1:0] SECTOR_BYTES = REM_W'(4096);
  localparam logic [REM_W-1:0] SECTOR_MASK  = REM_W'(4095);
  localparam logic [REM_W-1:0] BLK32_BYTES  = REM_W'(32768);
  localparam logic [REM_W-1:0] BLK64_BYTES  = REM_W'(65536);

  localparam logic [7:0] CMD_SECTOR = 8'h20;
  localparam logic [7:0] CMD_BLK32  = 8'h52;
  localparam logic [7:0] CMD_BLK64  = 8'hd8;

  typedef enum logic [1:0] {
    KIND_SECTOR = 2'd0,
    KIND_BLK32  = 2'd1,
    KIND_BLK64  = 2'd2
  } erase_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // One planned erase operation and the cursor after it.
  typedef struct packed {
    erase_kind_t       kind;
    logic [7:0]        cmd;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] next_addr;
    logic [REM_W-1:0]  next_rem;
    logic              done;
  } step_t;

endpackage

### hdl/sfep_step.sv
module sfep_step (
  input  logic [sfep_pkg::ADDR_W-1:0] addr,
  input  logic [sfep_pkg::REM_W-1:0]  rem,
  output sfep_pkg::step_t             step
);
  import sfep_pkg::*;

  logic             fit64;
  logic             fit32;
  logic [REM_W-1:0] len;
  logic [REM_W-1:0] rem_diff;

  assign fit64 = (addr[15:0] == 16'd0) && (rem >= BLK64_BYTES);
  assign fit32 = (addr[14:0] == 15'd0) && (rem >= BLK32_BYTES);

  always_comb begin
    step.addr = addr;
    if (fit64) begin
      step.kind = KIND_BLK64;
      step.cmd  = CMD_BLK64;
      len       = BLK64_BYTES;
    end else if (fit32) begin
      step.kind = KIND_BLK32;
      step.cmd  = CMD_BLK32;
      len       = BLK32_BYTES;
    end else begin
      step.kind = KIND_SECTOR;
      step.cmd  = CMD_SECTOR;
      len       = SECTOR_BYTES;
    end
    rem_diff       = rem - len;
    step.next_addr = addr + len[ADDR_W-1:0];
    step.next_rem  = (rem >= len) ? rem_diff : '0;
    step.done      = (step.next_rem == '0);
  end

endmodule

### hdl/spi_flash_erase_planner.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------------
// request  | in_valid/in_stall  | start_address, byte_count
// erase op | out_valid/out_stall| erase_kind, command_byte, erase_address, last_op
//
// A request is loaded, then one erase operation is produced per cycle while
// out_stall is low (up to 48), all by a single step unit (compares and a subtract).
// A zero byte_count is taken and gives no operations.
// in_stall stays high from the cycle after a nonzero request is loaded until its
// last operation has entered the output register.
// out_stall freezes the sequencer and the output register; rst is synchronous.
module spi_flash_erase_planner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sfep_pkg::START_W-1:0]  start_address,
  input  logic [sfep_pkg::COUNT_W-1:0]  byte_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    erase_kind,
  output logic [7:0]                    command_byte,
  output logic [sfep_pkg::ADDR_W-1:0]   erase_address,
  output logic                          last_op
);
  import sfep_pkg::*;

  state_t            state;
  logic [ADDR_W-1:0] cur_addr;
  logic [REM_W-1:0]  rem;
  logic [OPS_W-1:0]  op_count;
  logic [REM_W-1:0]  rem_sum;
  logic [REM_W-1:0]  rem_init;
  logic              take_in;
  logic              load_out;
  logic              run_end;
  step_t             step;

  sfep_step u_step (
    .addr (cur_addr),
    .rem  (rem),
    .step (step)
  );

  assign in_stall = (state != ST_IDLE);
  assign take_in  = in_valid && (state == ST_IDLE);
  assign load_out = (state == ST_RUN) && (!out_valid || !out_stall);
  assign run_end  = step.done || (op_count == OPS_W'(MAX_OPS - 1));

  // Widen to whole sectors: add the in-sector offset, round up.
  assign rem_sum  = REM_W'(byte_count) + REM_W'(start_address[11:0]) + SECTOR_MASK;
  assign rem_init = {rem_sum[REM_W-1:12], 12'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      op_count  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
          end
          if (take_in && (byte_count != '0)) begin
            state    <= ST_RUN;
            op_count <= '0;
          end
        end
        ST_RUN: begin
          if (load_out) begin
            out_valid <= 1'b1;
            op_count  <= op_count + OPS_W'(1);
            if (run_end) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state     <= ST_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  // Datapath: cursor and output register.
  always_ff @(posedge clk) begin
    if (take_in) begin
      cur_addr <= {1'b0, start_address[START_W-1:12], 12'd0};
      rem      <= rem_init;
    end else if (load_out) begin
      cur_addr <= step.next_addr;
      rem      <= step.next_rem;
    end
    if (load_out) begin
      erase_kind    <= step.kind;
      command_byte  <= step.cmd;
      erase_address <= step.addr;
      last_op       <= step.done;
    end
  end

endmodule

### hdl/sfep_checker.sv
`include "assert_macros.svh"

module sfep_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [sfep_pkg::COUNT_W-1:0]  byte_count,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    erase_kind,
  input logic [7:0]                    command_byte,
  input logic [sfep_pkg::ADDR_W-1:0]   erase_address,
  input logic                          last_op
);
  import sfep_pkg::*;

  logic cmd_ok;
  logic addr_ok;

  assign cmd_ok = ((erase_kind == KIND_SECTOR) && (command_byte == CMD_SECTOR)) ||
                  ((erase_kind == KIND_BLK32) && (command_byte == CMD_BLK32)) ||
                  ((erase_kind == KIND_BLK64) && (command_byte == CMD_BLK64));

  assign addr_ok = (erase_address[11:0] == 12'd0) &&
                   ((erase_kind != KIND_BLK32) || (erase_address[14:0] == 15'd0)) &&
                   ((erase_kind != KIND_BLK64) || (erase_address[15:0] == 16'd0));

  // A nonzero request blocks the next transaction while it is planned.
  `ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall && (byte_count != '0), in_stall)

  // Opcode follows the erase size.
  `ASSERT_IMPLY(a_cmd_matches_kind, out_valid, cmd_ok)

  // Every address is aligned to the size of its erase.
  `ASSERT_IMPLY(a_addr_aligned, out_valid, addr_ok)

  // Hold a stalled transaction.
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(erase_address) && $stable(erase_kind) && $stable(last_op))

endmodule

bind spi_flash_erase_planner sfep_checker u_sfep_checker (.*);

### tb/tb_spi_flash_erase_planner.sv
module tb_spi_flash_erase_planner;
  import sfep_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_REQUESTS = 207;
  localparam int SHOWN_MISMATCHES = 40;

  typedef struct packed {
    erase_kind_t       kind;
    logic [7:0]        cmd;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } erase_op_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] count;
    logic               typed;
    erase_kind_t        kind;
    logic [7:0]         cmd;
    logic [ADDR_W-1:0]  addr;
  } request_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [START_W-1:0] start_address = '0;
  logic [COUNT_W-1:0] byte_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] erase_kind;
  logic [7:0] command_byte;
  logic [ADDR_W-1:0] erase_address;
  logic last_op;

  erase_op_t    pending_ops[$];
  request_row_t directed_rows[$];

  int  cycle_count = 0;
  int  mismatch_count = 0;
  int  requests_sent = 0;
  int  empty_requests = 0;
  int  ops_checked = 0;
  int  kind_seen[3] = '{0, 0, 0};
  int  stall_left = 0;
  int  flow_left = 0;
  bit  no_idle = 1'b0;

  spi_flash_erase_planner dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .start_address (start_address),
    .byte_count    (byte_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .erase_kind    (erase_kind),
    .command_byte  (command_byte),
    .erase_address (erase_address),
    .last_op       (last_op)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= SHOWN_MISMATCHES)
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Widen to whole sectors, then pick the largest erase that fits at each step.
  task automatic plan_erase(input logic [START_W-1:0] start, input logic [COUNT_W-1:0] count);
    logic [REM_W-1:0]  left;
    logic [REM_W-1:0]  len;
    logic [ADDR_W-1:0] cursor;
    erase_op_t         op;
    int                n;
    if (count == '0) begin
      empty_requests++;
      return;
    end
    left = REM_W'(count) + (REM_W'(start) & SECTOR_MASK);
    left = (left + SECTOR_MASK) & ~SECTOR_MASK;
    cursor = ADDR_W'(start) & ~ADDR_W'(SECTOR_MASK);
    n = 0;
    while (left != '0 && n < MAX_OPS) begin
      if (cursor[15:0] == '0 && left >= BLK64_BYTES) begin
        op.kind = KIND_BLK64;
        op.cmd = CMD_BLK64;
        len = BLK64_BYTES;
      end else if (cursor[14:0] == '0 && left >= BLK32_BYTES) begin
        op.kind = KIND_BLK32;
        op.cmd = CMD_BLK32;
        len = BLK32_BYTES;
      end else begin
        op.kind = KIND_SECTOR;
        op.cmd = CMD_SECTOR;
        len = SECTOR_BYTES;
      end
      op.addr = cursor;
      cursor = cursor + ADDR_W'(len);
      left = (left >= len) ? left - len : '0;
      op.last = (left == '0);
      pending_ops.push_back(op);
      n++;
    end
  endtask

  task automatic check_op();
    erase_op_t want;
    if (pending_ops.size() == 0) begin
      report_mismatch($sformatf("erase op at 0x%06h with no transaction pending", erase_address));
      return;
    end
    want = pending_ops.pop_front();
    ops_checked++;
    if (erase_kind <= 2'd2) kind_seen[erase_kind]++;
    if (erase_kind !== want.kind)
      report_mismatch($sformatf("erase_kind %0d, want %0d", erase_kind, want.kind));
    if (command_byte !== want.cmd)
      report_mismatch($sformatf("command_byte 0x%02h, want 0x%02h", command_byte, want.cmd));
    if (erase_address !== want.addr)
      report_mismatch($sformatf("erase_address 0x%06h, want 0x%06h", erase_address, want.addr));
    if (last_op !== want.last)
      report_mismatch($sformatf("last_op %0b, want %0b at 0x%06h", last_op, want.last, want.addr));
  endtask

  task automatic send_request(input logic [START_W-1:0] addr, input logic [COUNT_W-1:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_address <= addr;
    byte_count <= len;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic add_row(input logic [START_W-1:0] s, input logic [COUNT_W-1:0] c,
                         input logic typed, input erase_kind_t k, input logic [7:0] cmd,
                         input logic [ADDR_W-1:0] a);
    request_row_t row;
    row.start = s;
    row.count = c;
    row.typed = typed;
    row.kind = k;
    row.cmd = cmd;
    row.addr = a;
    directed_rows.push_back(row);
  endtask

  task automatic draw_request(output logic [START_W-1:0] s, output logic [COUNT_W-1:0] c);
    int sel;
    sel = $urandom_range(0, 99);
    s = START_W'($urandom);
    if (sel < 8) begin
      c = '0;
    end else if (sel < 58) begin
      c = COUNT_W'($urandom_range(1, 32'h30000));
    end else if (sel < 78) begin
      // sector- or block-aligned start, count on or one below a sector multiple
      case ($urandom_range(0, 2))
        0: s = s & ~START_W'(20'hfff);
        1: s = s & ~START_W'(20'h7fff);
        default: s = s & ~START_W'(20'hffff);
      endcase
      c = (COUNT_W'($urandom_range(1, 40)) << 12) - COUNT_W'($urandom_range(0, 1));
    end else if (sel < 90) begin
      s = s & ~START_W'(20'h7fff);
      c = COUNT_W'($urandom_range(1, 12)) * COUNT_W'(32768);
    end else if (sel < 96) begin
      c = COUNT_W'($urandom_range(32'h100000, 32'h1fffff));
    end else begin
      c = COUNT_W'($urandom);
    end
  endtask

  // Check accepted erase ops, toss random output stalls, guard the run time.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && out_valid && !out_stall)
      check_op();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (flow_left > 0) begin
      out_stall <= 1'b0;
      flow_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
      flow_left = $urandom_range(1, 16);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles, %0d ops still pending",
               cycle_count, pending_ops.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [START_W-1:0] s;
    logic [COUNT_W-1:0] c;
    erase_op_t          op;
    int                 wait_cycles;

    add_row(20'h00000, 21'h000000, 1'b1, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'h00000, 21'h000001, 1'b1, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'hfffff, 21'h000001, 1'b1, KIND_SECTOR, CMD_SECTOR, 21'h0ff000);
    add_row(20'h00000, 21'h010000, 1'b1, KIND_BLK64,  CMD_BLK64,  21'h000000);
    add_row(20'h00000, 21'h00ffff, 1'b1, KIND_BLK64,  CMD_BLK64,  21'h000000);
    add_row(20'h08000, 21'h008000, 1'b1, KIND_BLK32,  CMD_BLK32,  21'h008000);
    add_row(20'h08000, 21'h007fff, 1'b1, KIND_BLK32,  CMD_BLK32,  21'h008000);
    add_row(20'h08000, 21'h000001, 1'b1, KIND_SECTOR, CMD_SECTOR, 21'h008000);
    add_row(20'h10000, 21'h001000, 1'b1, KIND_SECTOR, CMD_SECTOR, 21'h010000);
    add_row(20'hfffff, 21'h000000, 1'b1, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'h00000, 21'h1fffff, 1'b0, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'hfffff, 21'h1fffff, 1'b0, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'h01000, 21'h1fffff, 1'b0, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'h0f001, 21'h1fffff, 1'b0, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'h00000, 21'h100000, 1'b0, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'hf0000, 21'h020000, 1'b0, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'h07fff, 21'h000002, 1'b0, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'h00800, 21'h010000, 1'b0, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'h00000, 21'h010001, 1'b0, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'h00fff, 21'h001001, 1'b0, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'h01000, 21'h00f000, 1'b0, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'haaaaa, 21'h155555, 1'b0, KIND_SECTOR, CMD_SECTOR, 21'h000000);
    add_row(20'h55555, 21'h0aaaaa, 1'b0, KIND_SECTOR, CMD_SECTOR, 21'h000000);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].start, directed_rows[i].count);
      if (!directed_rows[i].typed) begin
        plan_erase(directed_rows[i].start, directed_rows[i].count);
      end else if (directed_rows[i].count == '0) begin
        empty_requests++;
      end else begin
        op.kind = directed_rows[i].kind;
        op.cmd = directed_rows[i].cmd;
        op.addr = directed_rows[i].addr;
        op.last = 1'b1;
        pending_ops.push_back(op);
      end
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      // run a stretch with no idling on either side
      no_idle = (i >= 100 && i < 140);
      draw_request(s, c);
      send_request(s, c);
      plan_erase(s, c);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_ops.size() != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 100) begin
      @(posedge clk);
      wait_cycles++;
    end

    while (pending_ops.size() != 0) begin
      op = pending_ops.pop_front();
      report_mismatch($sformatf("erase op at 0x%06h never arrived", op.addr));
    end

    $display("%0d requests sent (%0d empty), %0d erase ops checked in %0d cycles",
             requests_sent, empty_requests, ops_checked, cycle_count);
    $display("erase mix: %0d sector, %0d 32K block, %0d 64K block, %0d mismatches",
             kind_seen[0], kind_seen[1], kind_seen[2], mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/sfep_pkg.sv
hdl/sfep_step.sv
hdl/spi_flash_erase_planner.sv
hdl/sfep_checker.sv
tb/tb_spi_flash_erase_planner.sv
